### rtl/uff_pkg.sv
// shared types, codes and constants for the uart ring buffer with rts/cts flow control
package uff_pkg;

	localparam int TX_DEPTH_DEF = 64;
	localparam int RX_DEPTH_DEF = 64;

	localparam int ACT_W   = 2;
	localparam int DATA_W  = 8;
	localparam int LVL_W   = 7;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [LVL_W-1:0] RTS_OFF_RST = LVL_W'(48);
	localparam logic [LVL_W-1:0] RTS_ON_RST  = LVL_W'(16);

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_LINE  = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RTS_OFF = 1'b0,
		REG_RTS_ON  = 1'b1
	} reg_idx_t;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [DATA_W-1:0] data;
		logic              batch_first;
		logic [LVL_W-1:0]  batch_count;
		logic              cts_active;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_data;
		logic              out_valid;
		logic [STAT_W-1:0] status;
		logic              rts_active;
		logic [LVL_W-1:0]  rx_count;
		logic [LVL_W-1:0]  tx_free;
		logic              tx_idle;
	} out_item_t;

	typedef struct packed {
		logic exec;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_full;
	} ctl_sts_t;

endpackage

### rtl/uff_if.sv
// request and result channel interfaces
interface uff_item_if import uff_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface uff_result_if import uff_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/uart_fifo_rts_cts_flow_control.sv
// top level of the uart ring buffer with rts/cts flow control
//
// item_ch takes one request per handshake: a host write of a tx byte, a host
// read of an rx byte, a byte from the line, or a transmitter ready tick with
// the partner's cts level. result_ch returns exactly one result per request,
// in order, with the byte moved (if any), a status code, the rts level and
// the rx count and tx free space after the request.
// A request accepted on a clock edge reads the ring memory on that edge, and
// its status is kept in a pending register; the output register then loads
// the result once it is empty or being taken, and item_ch is ready again
// from that load on, as the ring memories have a registered read port.
// When result_ch stalls, the result waits in the output register and one
// more request can still be accepted; its result is held inside until the
// output register is taken, and item_ch stays low meanwhile.
// Reset empties both rings, asserts rts and sets the rts off and on levels
// to 48 and 16. Write the levels through cfg_we, cfg_idx and cfg_wdata only
// while no request is in flight.
module uart_fifo_rts_cts_flow_control import uff_pkg::*; #(
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [LVL_W-1:0]     cfg_wdata,
	uff_item_if.sink             item_ch,
	uff_result_if.source         result_ch
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	uff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_ch.valid),
		.out_ready (result_ch.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (item_ch.ready)
	);

	uff_dp #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch.payload),
		.cmd       (cmd),
		.out_ready (result_ch.ready),
		.sts       (sts),
		.res       (result_ch.payload),
		.res_valid (result_ch.valid)
	);

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_ch.valid && item_ch.ready |=> !item_ch.ready)
		else $error("request accepted while another is in flight");

	a_load_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !cmd.load)
		else $error("request executed while a result is being loaded");

	a_byte_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.payload.out_valid |->
		result_ch.payload.status == ST_OK && !result_ch.payload.tx_idle)
		else $error("result carries a byte with a non-ok status");

	a_idle_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.payload.tx_idle |->
		result_ch.payload.status == ST_EMPTY && !result_ch.payload.out_valid)
		else $error("tx idle result without empty status");
`endif

endmodule

### rtl/uff_ram.sv
// generic single-write, single-read ram with registered read data
module uff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/uff_ctrl.sv
// request sequencing state machine
module uff_ctrl import uff_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd,
	output logic     in_ready
);

	typedef enum logic {
		S_IDLE,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   rdy_q;

	assign cmd.exec = rdy_q & in_valid;
	assign cmd.load = (state_q == S_LOAD) & (~sts.out_full | out_ready);
	assign in_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOAD;
						rdy_q   <= 1'b0;
					end
				end
				S_LOAD: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule

### rtl/uff_dp.sv
// ring indices, fill counts, flow control state, ring memories and result register
module uff_dp import uff_pkg::*; #(
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [LVL_W-1:0]     cfg_wdata,
	input  in_item_t             item,
	input  ctl_cmd_t             cmd,
	input  logic                 out_ready,
	output ctl_sts_t             sts,
	output out_item_t            res,
	output logic                 res_valid
);

	localparam int TXI = $clog2(TX_DEPTH);
	localparam int TXC = $clog2(TX_DEPTH + 1);
	localparam int RXI = $clog2(RX_DEPTH);
	localparam int RXC = $clog2(RX_DEPTH + 1);
	localparam int TCW = (TXC > LVL_W) ? TXC : LVL_W;
	localparam int RCW = (RXC > LVL_W) ? RXC : LVL_W;

	typedef struct packed {
		logic              has_data;
		logic              from_tx;
		logic [STAT_W-1:0] status;
		logic              rts_active;
		logic [LVL_W-1:0]  rx_count;
		logic [LVL_W-1:0]  tx_free;
		logic              tx_idle;
	} pend_t;

	function automatic logic [TXI-1:0] tx_adv(input logic [TXI-1:0] i);
		return (i == TXI'(TX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [RXI-1:0] rx_adv(input logic [RXI-1:0] i);
		return (i == RXI'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [TXI-1:0]   tx_wr_q, tx_rd_q, tx_wr_nx, tx_rd_nx;
	logic [TXC-1:0]   tx_fill_q, tx_fill_nx;
	logic [RXI-1:0]   rx_wr_q, rx_rd_q, rx_wr_nx, rx_rd_nx;
	logic [RXC-1:0]   rx_fill_q, rx_fill_nx;
	logic             rts_q, rts_nx;
	logic             brej_q, brej_nx;
	logic [LVL_W-1:0] off_q, on_q;
	pend_t            pend_q, pend_nx;
	out_item_t        out_q;
	logic             out_vld_q;

	logic             tx_we, tx_re, rx_we, rx_re;
	logic [DATA_W-1:0] tx_rdata, rx_rdata;
	logic [TCW-1:0]   tx_free_cur;
	logic             rej;

	always_comb begin
		tx_wr_nx   = tx_wr_q;
		tx_rd_nx   = tx_rd_q;
		tx_fill_nx = tx_fill_q;
		rx_wr_nx   = rx_wr_q;
		rx_rd_nx   = rx_rd_q;
		rx_fill_nx = rx_fill_q;
		rts_nx     = rts_q;
		brej_nx    = brej_q;
		tx_we      = 1'b0;
		tx_re      = 1'b0;
		rx_we      = 1'b0;
		rx_re      = 1'b0;
		pend_nx    = '0;
		tx_free_cur = TCW'(TX_DEPTH) - TCW'(tx_fill_q);
		rej        = TCW'(item.batch_count) > tx_free_cur;

		unique case (action_t'(item.action))
			ACT_WRITE: begin
				if (item.batch_first) begin
					brej_nx = rej;
				end
				if (brej_nx || tx_fill_q == TXC'(TX_DEPTH)) begin
					pend_nx.status = ST_REJECT;
				end else begin
					tx_we      = 1'b1;
					tx_wr_nx   = tx_adv(tx_wr_q);
					tx_fill_nx = tx_fill_q + 1'b1;
				end
			end
			ACT_READ: begin
				if (rx_fill_q != '0) begin
					rx_re            = 1'b1;
					rx_rd_nx         = rx_adv(rx_rd_q);
					rx_fill_nx       = rx_fill_q - 1'b1;
					pend_nx.has_data = 1'b1;
				end else begin
					pend_nx.status = ST_EMPTY;
				end
				if (RCW'(rx_fill_nx) <= RCW'(on_q)) begin
					rts_nx = 1'b1;
				end
			end
			ACT_LINE: begin
				if (rx_fill_q != RXC'(RX_DEPTH)) begin
					rx_we      = 1'b1;
					rx_wr_nx   = rx_adv(rx_wr_q);
					rx_fill_nx = rx_fill_q + 1'b1;
				end else begin
					pend_nx.status = ST_REJECT;
				end
				if (RCW'(rx_fill_nx) >= RCW'(off_q)) begin
					rts_nx = 1'b0;
				end
			end
			ACT_TICK: begin
				if (tx_fill_q == '0) begin
					pend_nx.status  = ST_EMPTY;
					pend_nx.tx_idle = 1'b1;
				end else if (!item.cts_active) begin
					pend_nx.status = ST_EMPTY;
				end else begin
					tx_re            = 1'b1;
					tx_rd_nx         = tx_adv(tx_rd_q);
					tx_fill_nx       = tx_fill_q - 1'b1;
					pend_nx.has_data = 1'b1;
					pend_nx.from_tx  = 1'b1;
				end
			end
		endcase

		pend_nx.rts_active = rts_nx;
		pend_nx.rx_count   = LVL_W'(rx_fill_nx);
		pend_nx.tx_free    = LVL_W'(TCW'(TX_DEPTH) - TCW'(tx_fill_nx));
	end

	uff_ram #(.WIDTH(DATA_W), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (cmd.exec & tx_we),
		.waddr (tx_wr_q),
		.wdata (item.data),
		.re    (cmd.exec & tx_re),
		.raddr (tx_rd_q),
		.rdata (tx_rdata)
	);

	uff_ram #(.WIDTH(DATA_W), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (cmd.exec & rx_we),
		.waddr (rx_wr_q),
		.wdata (item.data),
		.re    (cmd.exec & rx_re),
		.raddr (rx_rd_q),
		.rdata (rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_q   <= '0;
			tx_rd_q   <= '0;
			tx_fill_q <= '0;
			rx_wr_q   <= '0;
			rx_rd_q   <= '0;
			rx_fill_q <= '0;
			rts_q     <= 1'b1;
			brej_q    <= 1'b0;
			off_q     <= RTS_OFF_RST;
			on_q      <= RTS_ON_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_RTS_OFF: off_q <= cfg_wdata;
					REG_RTS_ON:  on_q  <= cfg_wdata;
				endcase
			end
			if (cmd.exec) begin
				tx_wr_q   <= tx_wr_nx;
				tx_rd_q   <= tx_rd_nx;
				tx_fill_q <= tx_fill_nx;
				rx_wr_q   <= rx_wr_nx;
				rx_rd_q   <= rx_rd_nx;
				rx_fill_q <= rx_fill_nx;
				rts_q     <= rts_nx;
				brej_q    <= brej_nx;
			end
			if (cmd.load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pend_q <= pend_nx;
		end
		if (cmd.load) begin
			out_q.out_data   <= pend_q.has_data ?
				(pend_q.from_tx ? tx_rdata : rx_rdata) : '0;
			out_q.out_valid  <= pend_q.has_data;
			out_q.status     <= pend_q.status;
			out_q.rts_active <= pend_q.rts_active;
			out_q.rx_count   <= pend_q.rx_count;
			out_q.tx_free    <= pend_q.tx_free;
			out_q.tx_idle    <= pend_q.tx_idle;
		end
	end

	assign sts.out_full = out_vld_q;
	assign res          = out_q;
	assign res_valid    = out_vld_q;

endmodule

### bench/uff_result_checker.sv
// result checker: tracks both rings and the rts level and compares every result of the block
`timescale 1ns / 100ps
module uff_result_checker import uff_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [LVL_W-1:0]     cfg_wdata,
	uff_item_if                  item_ch,
	uff_result_if                result_ch,
	output int                   mismatches,
	output int                   pending
);

	localparam int TX_DEPTH = TX_DEPTH_DEF;
	localparam int RX_DEPTH = RX_DEPTH_DEF;
	localparam int TXI = $clog2(TX_DEPTH);
	localparam int RXI = $clog2(RX_DEPTH);
	localparam int REPORT_LIMIT = 10;

	logic [DATA_W-1:0] tx_ring [TX_DEPTH];
	logic [DATA_W-1:0] rx_ring [RX_DEPTH];
	int                tx_wr;
	int                tx_rd;
	int                tx_fill;
	int                rx_wr;
	int                rx_rd;
	int                rx_fill;
	logic              rts_level;
	logic              batch_refused;
	logic [LVL_W-1:0]  off_level;
	logic [LVL_W-1:0]  on_level;
	out_item_t         due_results [$];
	out_item_t         want;
	out_item_t         got;
	int                reported;

	function automatic out_item_t step_rings(input in_item_t req);
		out_item_t r;
		r = '0;
		r.status = ST_OK;
		case (req.action)
			ACT_WRITE: begin
				if (req.batch_first)
					batch_refused = int'(req.batch_count) > (TX_DEPTH - tx_fill);
				if (batch_refused || tx_fill >= TX_DEPTH) begin
					r.status = ST_REJECT;
				end else begin
					tx_ring[TXI'(tx_wr)] = req.data;
					tx_wr = (tx_wr + 1) % TX_DEPTH;
					tx_fill++;
				end
			end
			ACT_READ: begin
				if (rx_fill > 0) begin
					r.out_data = rx_ring[RXI'(rx_rd)];
					r.out_valid = 1'b1;
					rx_rd = (rx_rd + 1) % RX_DEPTH;
					rx_fill--;
				end else begin
					r.status = ST_EMPTY;
				end
				if (rx_fill <= int'(on_level))
					rts_level = 1'b1;
			end
			ACT_LINE: begin
				if (rx_fill < RX_DEPTH) begin
					rx_ring[RXI'(rx_wr)] = req.data;
					rx_wr = (rx_wr + 1) % RX_DEPTH;
					rx_fill++;
				end else begin
					r.status = ST_REJECT;
				end
				if (rx_fill >= int'(off_level))
					rts_level = 1'b0;
			end
			default: begin
				if (tx_fill == 0) begin
					r.status = ST_EMPTY;
					r.tx_idle = 1'b1;
				end else if (!req.cts_active) begin
					r.status = ST_EMPTY;
				end else begin
					r.out_data = tx_ring[TXI'(tx_rd)];
					r.out_valid = 1'b1;
					tx_rd = (tx_rd + 1) % TX_DEPTH;
					tx_fill--;
				end
			end
		endcase
		r.rts_active = rts_level;
		r.rx_count = LVL_W'(rx_fill);
		r.tx_free = LVL_W'(TX_DEPTH - tx_fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr = 0;
			tx_rd = 0;
			tx_fill = 0;
			rx_wr = 0;
			rx_rd = 0;
			rx_fill = 0;
			rts_level = 1'b1;
			batch_refused = 1'b0;
			off_level = RTS_OFF_RST;
			on_level = RTS_ON_RST;
			due_results.delete();
			mismatches = 0;
			reported = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_RTS_OFF: off_level = cfg_wdata;
					REG_RTS_ON:  on_level = cfg_wdata;
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.payload;
				if (due_results.size() == 0) begin
					mismatches++;
					if (reported < REPORT_LIMIT)
						$display({"unexpected result: data %h valid %b status %0d",
							" rts %b rx %0d free %0d idle %b"},
							got.out_data, got.out_valid, got.status, got.rts_active,
							got.rx_count, got.tx_free, got.tx_idle);
					reported++;
				end else begin
					want = due_results.pop_front();
					if (got.out_data !== want.out_data ||
					    got.out_valid !== want.out_valid ||
					    got.status !== want.status ||
					    got.rts_active !== want.rts_active ||
					    got.rx_count !== want.rx_count ||
					    got.tx_free !== want.tx_free ||
					    got.tx_idle !== want.tx_idle) begin
						mismatches++;
						if (reported < REPORT_LIMIT) begin
							$display({"mismatch expected: data %h valid %b status %0d",
								" rts %b rx %0d free %0d idle %b"},
								want.out_data, want.out_valid, want.status,
								want.rts_active, want.rx_count, want.tx_free,
								want.tx_idle);
							$display({"         actual:   data %h valid %b status %0d",
								" rts %b rx %0d free %0d idle %b"},
								got.out_data, got.out_valid, got.status,
								got.rts_active, got.rx_count, got.tx_free,
								got.tx_idle);
						end
						reported++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready)
				due_results.push_back(step_rings(item_ch.payload));
			pending <= due_results.size();
		end
	end

endmodule

### bench/tb.sv
// testbench top: request stimulus, result back-pressure, level writes and the verdict
`timescale 1ns / 100ps
module tb;
	import uff_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REQUEST_TARGET = 925;

	typedef enum int {MIX_TX, MIX_RX, MIX_BROKEN, MIX_NOISE} mix_t;
	typedef enum int {RDY_OPEN, RDY_COIN, RDY_HOLD} rdy_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [LVL_W-1:0]     cfg_wdata;
	int                   mismatches;
	int                   pending;
	int                   sent;
	int                   burst_left;
	int                   level_step;
	int                   cycles;

	uff_item_if   item_ch ();
	uff_result_if result_ch ();

	uart_fifo_rts_cts_flow_control u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item_ch   (item_ch),
		.result_ch (result_ch)
	);

	uff_result_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.item_ch    (item_ch),
		.result_ch  (result_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic in_item_t req(input action_t act, input logic [DATA_W-1:0] d,
		input logic first, input logic [LVL_W-1:0] cnt, input logic cts);
		in_item_t it;
		it.action = act;
		it.data = d;
		it.batch_first = first;
		it.batch_count = cnt;
		it.cts_active = cts;
		return it;
	endfunction

	function automatic in_item_t rand_req(input action_t act);
		return req(act, DATA_W'($urandom), 1'($urandom), LVL_W'($urandom), 1'($urandom));
	endfunction

	function automatic int pick_bias();
		case ($urandom_range(0, 3))
			0: return 10;
			1: return 50;
			2: return 80;
			default: return 95;
		endcase
	endfunction

	task automatic send_request(input in_item_t it);
		int gap_len;
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap_len = $urandom_range(1, 10);
			item_ch.valid <= 1'b0;
			repeat (gap_len) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 15);
		end
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_levels(input logic [LVL_W-1:0] off_lvl, input logic [LVL_W-1:0] on_lvl);
		cfg_we <= 1'b1;
		cfg_idx <= REG_RTS_OFF;
		cfg_wdata <= off_lvl;
		@(posedge clk);
		cfg_idx <= REG_RTS_ON;
		cfg_wdata <= on_lvl;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic next_levels();
		case (level_step % 6)
			0: set_levels(LVL_W'(0), LVL_W'(0));
			1: set_levels(LVL_W'(64), LVL_W'(64));
			2: set_levels(LVL_W'(64), LVL_W'(0));
			3: set_levels(LVL_W'(0), LVL_W'(64));
			4: set_levels(RTS_OFF_RST, RTS_ON_RST);
			default: set_levels(LVL_W'($urandom_range(0, 64)), LVL_W'($urandom_range(0, 64)));
		endcase
		level_step++;
	endtask

	task automatic run_mix(input mix_t kind, input int n, input int bias);
		int       left;
		int       cnt;
		in_item_t it;
		left = 0;
		for (int i = 0; i < n; i++) begin
			case (kind)
				MIX_TX: begin
					if ($urandom_range(1, 100) > bias) begin
						it = rand_req(ACT_TICK);
						it.cts_active = ($urandom_range(0, 4) != 0);
					end else if (left == 0) begin
						cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64)
							: $urandom_range(1, 8);
						it = rand_req(ACT_WRITE);
						it.batch_first = 1'b1;
						it.batch_count = LVL_W'(cnt);
						left = cnt - 1;
					end else begin
						it = rand_req(ACT_WRITE);
						it.batch_first = 1'b0;
						left--;
					end
				end
				MIX_RX: begin
					it = rand_req(($urandom_range(1, 100) <= bias) ? ACT_LINE : ACT_READ);
				end
				MIX_BROKEN: begin
					if ($urandom_range(0, 5) == 0) begin
						it = rand_req(ACT_TICK);
					end else if (left == 0) begin
						it = rand_req(ACT_WRITE);
						it.batch_first = 1'b1;
						left = $urandom_range(0, 70);
					end else begin
						it = rand_req(ACT_WRITE);
						it.batch_first = 1'b0;
						left--;
					end
				end
				default: begin
					it = rand_req(action_t'($urandom_range(0, 3)));
				end
			endcase
			send_request(it);
		end
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		begin : receiver
			int        run_left;
			rdy_mode_t mode;
			run_left = 0;
			mode = RDY_OPEN;
			forever begin
				@(posedge clk);
				if (run_left == 0) begin
					mode = rdy_mode_t'($urandom_range(0, 2));
					run_left = (mode == RDY_HOLD) ? $urandom_range(1, 12) : $urandom_range(10, 60);
				end
				run_left--;
				case (mode)
					RDY_OPEN: result_ch.ready <= 1'b1;
					RDY_COIN: result_ch.ready <= 1'($urandom);
					default:  result_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("uart_fifo_rts_cts_flow_control verification failed");
		$finish;
	end

	initial begin
		int phase_no;
		mix_t kind;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_RTS_OFF;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.payload <= '0;
		sent = 0;
		burst_left = 0;
		level_step = 0;
		phase_no = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_levels(LVL_W'(1), LVL_W'(0));
		// empty rings, cts low waits, then a short batch goes out
		send_request(req(ACT_READ, 8'h00, 1'b0, 7'd0, 1'b0));
		send_request(req(ACT_TICK, 8'hFF, 1'b1, 7'h7F, 1'b1));
		send_request(req(ACT_TICK, 8'h00, 1'b0, 7'd0, 1'b0));
		send_request(req(ACT_WRITE, 8'h00, 1'b1, 7'd3, 1'b0));
		send_request(req(ACT_WRITE, 8'hFF, 1'b0, 7'd0, 1'b1));
		send_request(req(ACT_WRITE, 8'hA5, 1'b0, 7'd0, 1'b0));
		send_request(req(ACT_TICK, 8'h00, 1'b0, 7'd0, 1'b0));
		repeat (3) send_request(req(ACT_TICK, 8'h77, 1'b0, 7'd0, 1'b1));
		// batch refusal and its clearing by a fitting first byte
		send_request(req(ACT_WRITE, 8'h5A, 1'b1, 7'd64, 1'b0));
		send_request(req(ACT_WRITE, 8'h11, 1'b1, 7'd64, 1'b0));
		send_request(req(ACT_WRITE, 8'h22, 1'b0, 7'd0, 1'b0));
		send_request(req(ACT_WRITE, 8'hC3, 1'b1, 7'd0, 1'b0));
		send_request(req(ACT_WRITE, 8'h3C, 1'b0, 7'd0, 1'b0));
		send_request(req(ACT_WRITE, 8'h99, 1'b1, 7'h7F, 1'b1));
		// rts drops on the first line byte and returns on the read that empties the rx ring
		send_request(req(ACT_LINE, 8'h00, 1'b0, 7'd0, 1'b0));
		send_request(req(ACT_LINE, 8'hFF, 1'b1, 7'h7F, 1'b1));
		repeat (3) send_request(req(ACT_READ, 8'hEE, 1'b0, 7'd0, 1'b1));
		repeat (3) send_request(req(ACT_TICK, 8'h00, 1'b0, 7'd0, 1'b1));
		wait_drained();
		next_levels();

		run_mix(MIX_TX, 80, 95);
		run_mix(MIX_RX, 80, 95);
		while (sent < REQUEST_TARGET) begin
			kind = mix_t'($urandom_range(0, 3));
			run_mix(kind, $urandom_range(10, 80), pick_bias());
			phase_no++;
			if (phase_no % 2 == 0) begin
				wait_drained();
				next_levels();
			end
		end
		wait_drained();

		if (mismatches == 0 && pending == 0)
			$display("uart_fifo_rts_cts_flow_control verification clean");
		else
			$display("uart_fifo_rts_cts_flow_control verification failed");
		$finish;
	end

endmodule
